FILE: hdl/cga_pkg.sv
package cga_pkg;

    localparam int MAX_ORDER   = 512;
    localparam int ORDER_W     = $clog2(MAX_ORDER) + 1;
    localparam int ELEM_W      = $clog2(MAX_ORDER);
    localparam int WORD_W      = 64;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int NUM_WORDS   = (MAX_ORDER + WORD_W - 1) / WORD_W;
    localparam int WIDX_W      = 3;
    localparam int WCNT_W      = WIDX_W + 1;
    localparam int TADDR_W     = 2 * ELEM_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_TABLE_WR = 2'd0;
    localparam logic [1:0] KIND_SET_WR   = 2'd1;
    localparam logic [1:0] KIND_QUERY    = 2'd2;
    localparam logic [1:0] KIND_NONE     = 2'd3;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_VALUE  = 2'd1;
    localparam logic [1:0] STAT_BEYOND = 2'd2;
    localparam logic [1:0] STAT_INDEX  = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        status;
        logic [ELEM_W-1:0] table_row;
        logic [ELEM_W-1:0] table_column;
        logic [ELEM_W-1:0] table_value;
        logic [WIDX_W-1:0] word_index;
        logic [WORD_W-1:0] set_word;
        logic [ELEM_W-1:0] query_vertex;
    } t_cmd;

endpackage

FILE: hdl/cga_front.sv
module cga_front import cga_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_kind,
    input  logic [ELEM_W-1:0]  i_table_row,
    input  logic [ELEM_W-1:0]  i_table_column,
    input  logic [ELEM_W-1:0]  i_table_value,
    input  logic [WIDX_W-1:0]  i_word_index,
    input  logic [WORD_W-1:0]  i_set_word,
    input  logic [ELEM_W-1:0]  i_query_vertex,
    input  logic [ORDER_W-1:0] i_grp_order,
    input  logic               i_q_full,
    output logic               o_q_push,
    output t_cmd               o_q_cmd
);

    logic [ORDER_W-1:0] w_words_sum;
    logic [WCNT_W-1:0]  w_words;
    logic [WCNT_W-1:0]  w_widx;
    logic [BIT_W-1:0]   w_tail_bits;
    logic [WORD_W-1:0]  w_tail_mask;
    logic [1:0]         w_status;

    assign w_words_sum = i_grp_order + ORDER_W'(WORD_W - 1);
    assign w_words     = w_words_sum[ORDER_W-1:BIT_W];
    assign w_widx      = {1'b0, i_word_index};
    assign w_tail_bits = i_grp_order[BIT_W-1:0];
    assign w_tail_mask = (w_tail_bits == '0) ? '1
                       : ((WORD_W'(1) << w_tail_bits) - WORD_W'(1));

    always_comb begin
        case (i_kind)
            KIND_TABLE_WR: begin
                if ({1'b0, i_table_row} >= i_grp_order
                        || {1'b0, i_table_column} >= i_grp_order) begin
                    w_status = STAT_INDEX;
                end else if ({1'b0, i_table_value} >= i_grp_order) begin
                    w_status = STAT_VALUE;
                end else begin
                    w_status = STAT_OK;
                end
            end
            KIND_SET_WR: begin
                if (w_widx >= w_words) begin
                    w_status = STAT_INDEX;
                end else if (w_widx == w_words - WCNT_W'(1)
                        && (i_set_word & ~w_tail_mask) != '0) begin
                    w_status = STAT_BEYOND;
                end else begin
                    w_status = STAT_OK;
                end
            end
            KIND_QUERY: begin
                if ({1'b0, i_query_vertex} >= i_grp_order || w_widx >= w_words) begin
                    w_status = STAT_INDEX;
                end else begin
                    w_status = STAT_OK;
                end
            end
            default: begin
                w_status = STAT_INDEX;
            end
        endcase
    end

    assign o_stall  = i_q_full;
    assign o_q_push = i_valid && !i_q_full;

    always_comb begin
        o_q_cmd.kind         = i_kind;
        o_q_cmd.status       = w_status;
        o_q_cmd.table_row    = i_table_row;
        o_q_cmd.table_column = i_table_column;
        o_q_cmd.table_value  = i_table_value;
        o_q_cmd.word_index   = i_word_index;
        o_q_cmd.set_word     = i_set_word;
        o_q_cmd.query_vertex = i_query_vertex;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_push && i_kind == KIND_NONE) |-> (o_q_cmd.status == STAT_INDEX))
        else $error("unknown kind not flagged");

endmodule

FILE: hdl/cga_queue.sv
module cga_queue import cga_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

FILE: hdl/cga_back.sv
module cga_back import cga_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [ORDER_W-1:0] i_grp_order,
    input  t_cmd               i_q_cmd,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [WORD_W-1:0]  o_adjacency_word,
    output logic [1:0]         o_status
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [ELEM_W-1:0] r_tbl [MAX_ORDER * MAX_ORDER];
    logic [ELEM_W-1:0] r_rd_data;

    logic [WORD_W-1:0] r_conn [NUM_WORDS];
    logic [1:0]        r_state;
    logic [ELEM_W-1:0] r_s;
    logic [ELEM_W-1:0] r_vertex;
    logic [WIDX_W-1:0] r_widx;
    logic              r_hit;
    logic              r_pend;
    logic [WORD_W-1:0] r_acc;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_adj;
    logic [1:0]        r_status;

    logic [WORD_W-1:0] n_acc;
    logic              w_slot_free;
    logic              w_pop;
    logic              w_tbl_we;
    logic              w_last;
    logic              w_member;
    logic              w_out_load;
    logic [TADDR_W-1:0] w_rd_addr;

    assign w_slot_free = !r_out_valid || !i_stall;
    assign w_pop       = (r_state == S_IDLE) && !i_q_empty && w_slot_free;
    assign o_q_pop     = w_pop;
    assign w_tbl_we    = w_pop && i_q_cmd.kind == KIND_TABLE_WR && i_q_cmd.status == STAT_OK;
    assign w_last      = ({1'b0, r_s} == i_grp_order - ORDER_W'(1));
    assign w_member    = r_conn[r_s[ELEM_W-1:BIT_W]][r_s[BIT_W-1:0]];
    assign w_rd_addr   = {r_s, r_vertex};
    assign w_out_load  = (w_pop && !(i_q_cmd.kind == KIND_QUERY && i_q_cmd.status == STAT_OK))
                       || (r_state == S_DRAIN);

    always_comb begin
        n_acc = r_acc;
        if (r_pend && r_hit && {1'b0, r_rd_data} < i_grp_order
                && r_rd_data[ELEM_W-1:BIT_W] == r_widx) begin
            n_acc = r_acc | (WORD_W'(1) << r_rd_data[BIT_W-1:0]);
        end
    end

    // product table, one read every cycle and at most one write beside it
    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_tbl[{i_q_cmd.table_row, i_q_cmd.table_column}] <= i_q_cmd.table_value;
        end
        r_rd_data <= r_tbl[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_hit <= w_member;
        if (w_pop) begin
            r_vertex <= i_q_cmd.query_vertex;
            r_widx   <= i_q_cmd.word_index;
            r_acc    <= '0;
        end else begin
            r_acc    <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_s         <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_adj       <= '0;
            r_status    <= STAT_OK;
            for (int i = 0; i < NUM_WORDS; i++) begin
                r_conn[i] <= '0;
            end
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            r_pend <= (r_state == S_WALK);
            case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        r_s <= '0;
                        if (i_q_cmd.kind == KIND_QUERY && i_q_cmd.status == STAT_OK) begin
                            r_state <= S_WALK;
                        end else begin
                            r_adj       <= '0;
                            r_status    <= i_q_cmd.status;
                        end
                        if (i_q_cmd.kind == KIND_SET_WR && i_q_cmd.status == STAT_OK) begin
                            r_conn[i_q_cmd.word_index] <= i_q_cmd.set_word;
                        end
                    end
                end
                S_WALK: begin
                    if (w_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_s <= r_s + ELEM_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_state     <= S_IDLE;
                    r_adj       <= n_acc;
                    r_status    <= STAT_OK;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_adjacency_word = r_adj;
    assign o_status         = r_status;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ({1'b0, r_s} < i_grp_order))
        else $error("walk index beyond order");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |=> (r_out_valid && r_state == S_IDLE))
        else $error("query result not presented");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != STAT_OK) |-> (r_adj == '0))
        else $error("nonzero word with error status");

endmodule

FILE: hdl/cayley_graph_adjacency_top.sv
// Cayley graph adjacency row builder. Load the product table (kind 0) and the
// connection set (kind 1), then ask for 64-bit row words (kind 2); every beat
// returns exactly one result beat, in order. Writes and rejected beats show
// their result in the cycle after the execution unit takes them from the
// queue. A query walks every element below the configured order through the
// one read port of the product table memory, one read a cycle; the result is
// registered in the drain state and no new beat is taken till then. A two-entry
// queue sits between the classifier and the execution unit; a result held by
// output stall holds the execution unit, while the queue still takes up to two
// beats. Only query entries that were written; the connection set clears at
// reset. Write the order register only while the block is idle.
module cayley_graph_adjacency_top import cga_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [ORDER_W-1:0] i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_kind,
    input  logic [ELEM_W-1:0]  i_table_row,
    input  logic [ELEM_W-1:0]  i_table_column,
    input  logic [ELEM_W-1:0]  i_table_value,
    input  logic [WIDX_W-1:0]  i_word_index,
    input  logic [WORD_W-1:0]  i_set_word,
    input  logic [ELEM_W-1:0]  i_query_vertex,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [WORD_W-1:0]  o_adjacency_word,
    output logic [1:0]         o_status
);

    logic [ORDER_W-1:0] r_grp_order;
    logic [ORDER_W-1:0] n_grp_order;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_cmd q_in;
    t_cmd q_out;

    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_grp_order = ORDER_W'(1);
        end else if (i_cfg_wdata > ORDER_W'(MAX_ORDER)) begin
            n_grp_order = ORDER_W'(MAX_ORDER);
        end else begin
            n_grp_order = i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_order <= ORDER_W'(MAX_ORDER);
        end else if (i_cfg_we) begin
            r_grp_order <= n_grp_order;
        end
    end

    cga_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_table_row    (i_table_row),
        .i_table_column (i_table_column),
        .i_table_value  (i_table_value),
        .i_word_index   (i_word_index),
        .i_set_word     (i_set_word),
        .i_query_vertex (i_query_vertex),
        .i_grp_order    (r_grp_order),
        .i_q_full       (q_full),
        .o_q_push       (q_push),
        .o_q_cmd        (q_in)
    );

    cga_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_empty (q_empty)
    );

    cga_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_grp_order      (r_grp_order),
        .i_q_cmd          (q_out),
        .i_q_empty        (q_empty),
        .o_q_pop          (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_adjacency_word (o_adjacency_word),
        .o_status         (o_status)
    );

endmodule
